// ===== rtl/att_pkg.sv =====
// Shared types and constants of the allocation tracking table.
package att_pkg;

  localparam int unsigned TableEntries = 32;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned AddrW = 48;
  localparam int unsigned SizeW = 32;
  localparam int unsigned CountW = 48;
  localparam int unsigned LiveW = 6;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REPORT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_RECORDED   = 3'd0,
    ST_TABLE_FULL = 3'd1,
    ST_ALLOC_FAIL = 3'd2,
    ST_FREED      = 3'd3,
    ST_UNMATCHED  = 3'd4,
    ST_LEAK       = 3'd5,
    ST_NO_LEAKS   = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [AddrW-1:0] address;
    logic [SizeW-1:0] request_size;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SizeW-1:0]  entry_bytes;
    logic [CountW-1:0] alloc_call_total;
    logic [CountW-1:0] alloc_byte_total;
    logic [CountW-1:0] free_call_total;
    logic [CountW-1:0] free_byte_total;
    logic [LiveW-1:0]  live_entries;
    logic              last;
  } res_t;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] address;
    logic [SizeW-1:0] size;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

// ===== rtl/allocation_tracking_table_top.sv =====
// Top level of the allocation tracking table.
// A command transfers on a clock edge with start high and busy low; busy rises
// only while the two-entry command queue is full. Allocate and free each run
// in the back end as a queue pop with a parallel address match over the slot
// table, then an update, giving one result that appears on result_o for one
// cycle with result_valid_o high. A report gives one leak result per live
// slot in slot order, or a single no-leaks result; last marks the final
// result of a command. Operation code 3 is dropped and gives no result.
// The receiver cannot stall and must take every result in the cycle it is
// shown. The slot table is empty after reset.
module allocation_tracking_table_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  att_pkg::cmd_t cmd_i,
  output logic          result_valid_o,
  output att_pkg::res_t result_o
);
  import att_pkg::*;

  head_t head;
  logic  pop;

  att_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .pop_i  (pop),
    .head_o (head)
  );

  att_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== rtl/att_front.sv =====
// Front end: command transfer, classification and a two-entry queue.
module att_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  att_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output att_pkg::head_t head_o
);
  import att_pkg::*;

  item_t      q_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       do_pop;
  item_t      item_in;

  assign busy = (cnt_q == 2'd2);

  always_comb begin
    item_in.op      = op_e'(cmd_i.operation);
    item_in.address = cmd_i.address;
    item_in.size    = cmd_i.request_size;
  end

  // drop the unused operation code at the door
  assign push   = start && !busy && (item_in.op != OP_NONE);
  assign do_pop = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = q_q[rd_ptr_q];

endmodule

// ===== rtl/att_back.sv =====
// Back end: slot table, saturating totals and result generation.
module att_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  att_pkg::head_t head_i,
  output logic           pop_o,
  output logic           result_valid_o,
  output att_pkg::res_t  result_o
);
  import att_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_REPORT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [AddrW-1:0]        slot_addr_q  [TableEntries];
  logic [SizeW-1:0]        slot_bytes_q [TableEntries];
  logic [TableEntries-1:0] slot_valid_q, slot_valid_d;
  logic [TableEntries-1:0] match_q, match_d;
  logic [TableEntries-1:0] empty_q, empty_d;

  item_t             cur_q;
  logic [LiveW-1:0]  live_q, live_d;
  logic [CountW-1:0] alloc_calls_q, alloc_calls_d;
  logic [CountW-1:0] alloc_bytes_q, alloc_bytes_d;
  logic [CountW-1:0] free_calls_q, free_calls_d;
  logic [CountW-1:0] freed_bytes_q, freed_bytes_d;

  res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  logic              wr_en;
  logic [IdxW-1:0]   wr_idx;
  logic [IdxW-1:0]   match_idx;
  logic [IdxW-1:0]   empty_idx;
  logic [IdxW-1:0]   live_idx;
  logic [TableEntries-1:0] remain;
  logic [2:0]        status;
  logic [SizeW-1:0]  bytes;
  logic              last;

  function automatic logic [IdxW-1:0] first_set(input logic [TableEntries-1:0] v);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IdxW'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] a,
                                                input logic [CountW-1:0] b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CountW] ? {CountW{1'b1}} : s[CountW-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      match_d[i] = slot_valid_q[i] && (slot_addr_q[i] == head_i.item.address);
    end
    empty_d = ~slot_valid_q;
  end

  assign match_idx = first_set(match_q);
  assign empty_idx = first_set(empty_q);
  assign live_idx  = first_set(slot_valid_q);

  always_comb begin
    state_d       = state_q;
    slot_valid_d  = slot_valid_q;
    live_d        = live_q;
    alloc_calls_d = alloc_calls_q;
    alloc_bytes_d = alloc_bytes_q;
    free_calls_d  = free_calls_q;
    freed_bytes_d = freed_bytes_q;
    res_valid_d   = 1'b0;
    pop_o         = 1'b0;
    wr_en         = 1'b0;
    wr_idx        = empty_idx;
    status        = ST_RECORDED;
    bytes         = '0;
    last          = 1'b1;
    remain        = slot_valid_q;

    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (cur_q.op)
          OP_ALLOC: begin
            res_valid_d   = 1'b1;
            alloc_calls_d = sat_add(alloc_calls_q, CountW'(1));
            alloc_bytes_d = sat_add(alloc_bytes_q, CountW'(cur_q.size));
            if (cur_q.address == '0) begin
              status = ST_ALLOC_FAIL;
            end else if (empty_q == '0) begin
              status = ST_TABLE_FULL;
            end else begin
              status               = ST_RECORDED;
              wr_en                = 1'b1;
              slot_valid_d[wr_idx] = 1'b1;
              live_d               = live_q + LiveW'(1);
            end
          end
          OP_FREE: begin
            res_valid_d  = 1'b1;
            free_calls_d = sat_add(free_calls_q, CountW'(1));
            if ((cur_q.address != '0) && (match_q != '0)) begin
              status                  = ST_FREED;
              bytes                   = slot_bytes_q[match_idx];
              slot_valid_d[match_idx] = 1'b0;
              freed_bytes_d           = sat_add(freed_bytes_q, CountW'(bytes));
              if (live_q != '0) begin
                live_d = live_q - LiveW'(1);
              end
            end else begin
              status = ST_UNMATCHED;
            end
          end
          OP_REPORT: begin
            if (slot_valid_q == '0) begin
              res_valid_d = 1'b1;
              status      = ST_NO_LEAKS;
            end else begin
              state_d = S_REPORT;
            end
          end
          default: begin
          end
        endcase
      end
      S_REPORT: begin
        res_valid_d            = 1'b1;
        status                 = ST_LEAK;
        bytes                  = slot_bytes_q[live_idx];
        remain[live_idx]       = 1'b0;
        slot_valid_d[live_idx] = 1'b0;
        last                   = (remain == '0);
        if (live_q != '0) begin
          live_d = live_q - LiveW'(1);
        end
        if (last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.status           = status;
    res_d.entry_bytes      = bytes;
    res_d.alloc_call_total = alloc_calls_d;
    res_d.alloc_byte_total = alloc_bytes_d;
    res_d.free_call_total  = free_calls_d;
    res_d.free_byte_total  = freed_bytes_d;
    res_d.live_entries     = live_d;
    res_d.last             = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      slot_valid_q  <= '0;
      live_q        <= '0;
      alloc_calls_q <= '0;
      alloc_bytes_q <= '0;
      free_calls_q  <= '0;
      freed_bytes_q <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      slot_valid_q  <= slot_valid_d;
      live_q        <= live_d;
      alloc_calls_q <= alloc_calls_d;
      alloc_bytes_q <= alloc_bytes_d;
      free_calls_q  <= free_calls_d;
      freed_bytes_q <= freed_bytes_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q   <= head_i.item;
      match_q <= match_d;
      empty_q <= empty_d;
    end
    if (wr_en) begin
      slot_addr_q[wr_idx]  <= cur_q.address;
      slot_bytes_q[wr_idx] <= cur_q.size;
    end
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
